// ===== rtl/ppp_pkg.sv =====
// shared types, widths and constants of the point projection pipeline
package ppp_pkg;

  localparam int PW    = 24;         // point and camera coordinate width, q15.8
  localparam int AW    = 12;         // angle width
  localparam int FW    = 20;         // focal length width, q12.8
  localparam int TW    = 16;         // sine and cosine width, q1.14 signed
  localparam int CW    = 28;         // rotation datapath width, q8
  localparam int SW    = 24;         // scale width, q8.16
  localparam int OW    = 32;         // screen coordinate width, q23.8
  localparam int QBITS = 24;         // quotient bits of the divider
  localparam int DVW   = FW + 16;    // dividend width
  localparam int DENW  = CW - 1;     // divisor width, depth is positive
  localparam int RIW   = 11;         // quarter wave table index width
  localparam int ROM_DEPTH = 1025;

  localparam int SCREEN_WIDTH_DEF  = 1024;
  localparam int SCREEN_HEIGHT_DEF = 1024;

  localparam logic signed [CW-1:0] NEAR_LIMIT = CW'(50 * 256);
  localparam logic [FW-1:0] FOCAL_RESET = FW'(25600);
  localparam logic signed [TW-1:0] TRIG_ONE = TW'(16384);

  localparam logic [2:0] CFG_CAMERA_X = 3'd0;
  localparam logic [2:0] CFG_CAMERA_Y = 3'd1;
  localparam logic [2:0] CFG_CAMERA_Z = 3'd2;
  localparam logic [2:0] CFG_ANGLE_X  = 3'd3;
  localparam logic [2:0] CFG_ANGLE_Y  = 3'd4;
  localparam logic [2:0] CFG_ANGLE_Z  = 3'd5;
  localparam logic [2:0] CFG_FOCAL    = 3'd6;

  typedef struct packed {
    logic signed [TW-1:0] sx;
    logic signed [TW-1:0] cx;
    logic signed [TW-1:0] sy;
    logic signed [TW-1:0] cy;
    logic signed [TW-1:0] sz;
    logic signed [TW-1:0] cz;
  } trig_t;

  typedef struct packed {
    logic                 vis;
    logic signed [OW-1:0] sx;
    logic signed [OW-1:0] sy;
    logic [SW-1:0]        scale;
  } res_t;

  // quarter wave sine in q14, evaluated at elaboration only
  function automatic logic [14:0] quad_sin(input int unsigned a);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint unsigned v;
    longint unsigned one;
    one = 64'd1 << 30;
    if (a <= 512) begin
      x  = longint'(a) * 64'd1647099;
      x2 = (x * x) >> 30;
      p  = one - x2 / 42;
      p  = one - ((x2 * p) >> 30) / 20;
      p  = one - ((x2 * p) >> 30) / 6;
      v  = (x * p) >> 30;
    end else begin
      x  = longint'(1024 - a) * 64'd1647099;
      x2 = (x * x) >> 30;
      p  = one - x2 / 56;
      p  = one - ((x2 * p) >> 30) / 30;
      p  = one - ((x2 * p) >> 30) / 12;
      p  = one - ((x2 * p) >> 30) / 2;
      v  = p;
    end
    return 15'((v + 64'd32768) >> 16);
  endfunction

endpackage

// ===== rtl/ppp_trig.sv =====
// sine and cosine lookup sequencer for the three camera angles
module ppp_trig (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ppp_pkg::AW-1:0]      angle_x_i,
  input  logic [ppp_pkg::AW-1:0]      angle_y_i,
  input  logic [ppp_pkg::AW-1:0]      angle_z_i,
  output logic                        busy_o,
  output ppp_pkg::trig_t              trig_o
);

  localparam logic [2:0] STEP_DONE = 3'd6;

  logic [14:0] rom [ppp_pkg::ROM_DEPTH];

  for (genvar g = 0; g < ppp_pkg::ROM_DEPTH; g++) begin : g_rom
    localparam logic [14:0] Val = ppp_pkg::quad_sin(g);
    assign rom[g] = Val;
  end

  logic [2:0]                   step_q;
  logic                         busy_q;
  logic                         pend_v_q;
  logic [2:0]                   pend_idx_q;
  logic                         pend_neg_q;
  logic [14:0]                  rom_q;
  logic signed [ppp_pkg::TW-1:0] val_q [6];

  logic [ppp_pkg::AW-1:0]  ang;
  logic [ppp_pkg::AW-1:0]  ang_f;
  logic [ppp_pkg::RIW-1:0] idx;
  logic                    neg;

  always_comb begin
    unique case (step_q[2:1])
      2'd0:    ang = angle_x_i;
      2'd1:    ang = angle_y_i;
      default: ang = angle_z_i;
    endcase
    // cosine is the sine a quarter turn ahead
    ang_f = step_q[0] ? ang + 12'd1024 : ang;
    if (ang_f <= 12'd1024) begin
      idx = ang_f[ppp_pkg::RIW-1:0];
      neg = 1'b0;
    end else if (ang_f <= 12'd2048) begin
      idx = ppp_pkg::RIW'(12'd2048 - ang_f);
      neg = 1'b0;
    end else if (ang_f <= 12'd3072) begin
      idx = ppp_pkg::RIW'(ang_f - 12'd2048);
      neg = 1'b1;
    end else begin
      idx = ppp_pkg::RIW'(13'd4096 - {1'b0, ang_f});
      neg = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rom_q <= rom[idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      step_q     <= 3'd0;
      pend_v_q   <= 1'b0;
      pend_idx_q <= 3'd0;
      pend_neg_q <= 1'b0;
    end else if (start_i) begin
      busy_q   <= 1'b1;
      step_q   <= 3'd0;
      pend_v_q <= 1'b0;
    end else if (busy_q) begin
      if (step_q != STEP_DONE) begin
        pend_v_q   <= 1'b1;
        pend_idx_q <= step_q;
        pend_neg_q <= neg;
        step_q     <= step_q + 3'd1;
      end else begin
        pend_v_q <= 1'b0;
        busy_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q[0] <= '0;
      val_q[1] <= ppp_pkg::TRIG_ONE;
      val_q[2] <= '0;
      val_q[3] <= ppp_pkg::TRIG_ONE;
      val_q[4] <= '0;
      val_q[5] <= ppp_pkg::TRIG_ONE;
    end else if (pend_v_q) begin
      val_q[pend_idx_q] <= pend_neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});
    end
  end

  assign busy_o    = busy_q;
  assign trig_o.sx = val_q[0];
  assign trig_o.cx = val_q[1];
  assign trig_o.sy = val_q[2];
  assign trig_o.cy = val_q[3];
  assign trig_o.sz = val_q[4];
  assign trig_o.cz = val_q[5];

endmodule

// ===== rtl/ppp_rot.sv =====
// one plane rotation, two stages: products, then rounded sums
module ppp_rot (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [ppp_pkg::CW-1:0] p_i,
  input  logic signed [ppp_pkg::CW-1:0] q_i,
  input  logic signed [ppp_pkg::CW-1:0] r_i,
  input  logic signed [ppp_pkg::TW-1:0] s_i,
  input  logic signed [ppp_pkg::TW-1:0] c_i,
  output logic                          valid_o,
  output logic signed [ppp_pkg::CW-1:0] u_o,
  output logic signed [ppp_pkg::CW-1:0] v_o,
  output logic signed [ppp_pkg::CW-1:0] r_o
);

  localparam int PRW = ppp_pkg::CW + ppp_pkg::TW;
  localparam logic [PRW:0] RND = (PRW+1)'(1 << 13);

  logic                          v1_q, v2_q;
  logic signed [PRW-1:0]         sp_q, cq_q, cp_q, sq_q;
  logic signed [ppp_pkg::CW-1:0] r1_q, r2_q, u_q, w_q;
  logic [PRW:0]                  su, sv;

  always_comb begin
    su = {sp_q[PRW-1], sp_q} + {cq_q[PRW-1], cq_q} + RND;
    sv = {cp_q[PRW-1], cp_q} - {sq_q[PRW-1], sq_q} + RND;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sp_q <= s_i * p_i;
      cq_q <= c_i * q_i;
      cp_q <= c_i * p_i;
      sq_q <= s_i * q_i;
      r1_q <= r_i;
      u_q  <= su[14 +: ppp_pkg::CW];
      w_q  <= sv[14 +: ppp_pkg::CW];
      r2_q <= r1_q;
    end
  end

  assign valid_o = v2_q;
  assign u_o     = u_q;
  assign v_o     = w_q;
  assign r_o     = r2_q;

endmodule

// ===== rtl/ppp_div.sv =====
// near test and pipelined restoring divider, one quotient bit per stage
module ppp_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [ppp_pkg::CW-1:0] rz_i,
  input  logic signed [ppp_pkg::CW-1:0] rx_i,
  input  logic signed [ppp_pkg::CW-1:0] ry_i,
  input  logic [ppp_pkg::FW-1:0]        focal_i,
  output logic                          valid_o,
  output logic                          vis_o,
  output logic [ppp_pkg::SW-1:0]        scale_o,
  output logic signed [ppp_pkg::CW-1:0] rx_o,
  output logic signed [ppp_pkg::CW-1:0] ry_o
);

  localparam int NQ  = ppp_pkg::QBITS;
  localparam int DSW = ppp_pkg::DENW + NQ;

  logic                          vld_q [NQ+1];
  logic                          vis_q [NQ+1];
  logic [ppp_pkg::DVW-1:0]       rem_q [NQ+1];
  logic [NQ-1:0]                 quo_q [NQ+1];
  logic [ppp_pkg::DENW-1:0]      den_q [NQ+1];
  logic signed [ppp_pkg::CW-1:0] rx_q  [NQ+1];
  logic signed [ppp_pkg::CW-1:0] ry_q  [NQ+1];

  logic [DSW-1:0]          den_sh [NQ];
  logic                    ge     [NQ];
  logic [ppp_pkg::DVW-1:0] rem_nx [NQ];
  logic [NQ-1:0]           quo_nx [NQ];

  always_comb begin
    for (int k = 0; k < NQ; k++) begin
      den_sh[k] = DSW'(den_q[k]) << (NQ - 1 - k);
      ge[k]     = DSW'(rem_q[k]) >= den_sh[k];
      rem_nx[k] = ge[k] ? rem_q[k] - den_sh[k][ppp_pkg::DVW-1:0] : rem_q[k];
      quo_nx[k] = quo_q[k];
      quo_nx[k][NQ-1-k] = ge[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NQ; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 0; k < NQ; k++) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vis_q[0] <= rz_i > ppp_pkg::NEAR_LIMIT;
      rem_q[0] <= {focal_i, 16'd0};
      quo_q[0] <= '0;
      den_q[0] <= rz_i[ppp_pkg::DENW-1:0];
      rx_q[0]  <= rx_i;
      ry_q[0]  <= ry_i;
      for (int k = 0; k < NQ; k++) begin
        vis_q[k+1] <= vis_q[k];
        rem_q[k+1] <= rem_nx[k];
        quo_q[k+1] <= quo_nx[k];
        den_q[k+1] <= den_q[k];
        rx_q[k+1]  <= rx_q[k];
        ry_q[k+1]  <= ry_q[k];
      end
    end
  end

  // quotient stays below 2^23 since the depth exceeds 12800
  assign valid_o = vld_q[NQ];
  assign vis_o   = vis_q[NQ];
  assign scale_o = quo_q[NQ][ppp_pkg::SW-1:0];
  assign rx_o    = rx_q[NQ];
  assign ry_o    = ry_q[NQ];

endmodule

// ===== rtl/ppp_out.sv =====
// screen mapping stages, saturation and output skid buffer
module ppp_out #(
  parameter int SCREEN_WIDTH  = ppp_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ppp_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic                          vis_i,
  input  logic [ppp_pkg::SW-1:0]        scale_i,
  input  logic signed [ppp_pkg::CW-1:0] rx_i,
  input  logic signed [ppp_pkg::CW-1:0] ry_i,
  input  logic                          out_ready_i,
  output logic                          pipe_en_o,
  output logic                          out_valid_o,
  output ppp_pkg::res_t                 res_o
);

  localparam int PMW = ppp_pkg::SW + 1 + ppp_pkg::CW;
  localparam int SHW = PMW - 16;
  localparam int ADW = SHW + 1;
  localparam logic [PMW-1:0] RND = PMW'(1 << 15);
  localparam logic signed [ADW-1:0] HALF_X = ADW'((SCREEN_WIDTH / 2) * 256);
  localparam logic signed [ADW-1:0] HALF_Y = ADW'((SCREEN_HEIGHT / 2) * 256);
  localparam logic signed [ADW-1:0] SAT_HI = ADW'(64'sh7FFFFFFF);
  localparam logic signed [ADW-1:0] SAT_LO = -ADW'(64'sh80000000);

  function automatic logic signed [ppp_pkg::OW-1:0] sat(input logic signed [ADW-1:0] v);
    if (v > SAT_HI) begin
      return ppp_pkg::OW'(SAT_HI);
    end else if (v < SAT_LO) begin
      return ppp_pkg::OW'(SAT_LO);
    end
    return v[ppp_pkg::OW-1:0];
  endfunction

  logic                   en;
  logic                   m_v_q, m_vis_q, fin_v_q, out_v_q, skid_v_q;
  logic [ppp_pkg::SW-1:0] m_scale_q;
  logic signed [PMW-1:0]  mx_q, my_q;
  logic [PMW-1:0]         rx_r, ry_r;
  logic signed [SHW-1:0]  shx, shy;
  logic signed [ADW-1:0]  ax, ay;
  ppp_pkg::res_t          fin_d, fin_q, out_q, skid_q;

  assign en = !skid_v_q;

  always_comb begin
    rx_r = mx_q + RND;
    ry_r = my_q + RND;
    shx  = rx_r[PMW-1:16];
    shy  = ry_r[PMW-1:16];
    ax   = {shx[SHW-1], shx} + HALF_X;
    ay   = {shy[SHW-1], shy} + HALF_Y;
    fin_d.vis   = m_vis_q;
    fin_d.sx    = m_vis_q ? sat(ax) : '0;
    fin_d.sy    = m_vis_q ? sat(ay) : '0;
    fin_d.scale = m_vis_q ? m_scale_q : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q      <= $signed({1'b0, scale_i}) * rx_i;
      my_q      <= $signed({1'b0, scale_i}) * ry_i;
      m_vis_q   <= vis_i;
      m_scale_q <= scale_i;
      fin_q     <= fin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q    <= 1'b0;
      fin_v_q  <= 1'b0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
      out_q    <= '0;
      skid_q   <= '0;
    end else begin
      if (en) begin
        m_v_q   <= valid_i;
        fin_v_q <= m_v_q;
      end
      if (skid_v_q) begin
        if (out_ready_i) begin
          out_q    <= skid_q;
          skid_v_q <= 1'b0;
        end
      end else if (!out_v_q || out_ready_i) begin
        out_v_q <= fin_v_q;
        out_q   <= fin_q;
      end else if (fin_v_q) begin
        skid_q   <= fin_q;
        skid_v_q <= 1'b1;
      end
    end
  end

  assign pipe_en_o   = en;
  assign out_valid_o = out_v_q;
  assign res_o       = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a transaction while output is empty");

  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_q.vis) |-> (out_q.sx == '0 && out_q.sy == '0 && out_q.scale == '0))
    else $error("hidden point with nonzero result fields");

  a_scale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.vis) |-> !out_q.scale[ppp_pkg::SW-1])
    else $error("scale beyond quotient bound");

endmodule

// ===== rtl/perspective_point_projection.sv =====
// top level of the perspective point projection pipeline
// an accepted input transaction passes 35 register stages on its way to out_valid_o:
//   1 offset, 3 x 2 rotation, 25 divider, 2 screen mapping, 1 output
// throughput: one transaction per cycle while in_ready_o is high, set by the fully pipelined divider
// after a write to an angle register, in_ready_o is low while the
//   six sines and cosines are read from the quarter wave table one per cycle
// reset: registers take their reset values (focal length 100.0), pipeline empties
module perspective_point_projection #(
  parameter int SCREEN_WIDTH  = ppp_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ppp_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [ppp_pkg::PW-1:0]        cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [ppp_pkg::PW-1:0] point_x_i,
  input  logic signed [ppp_pkg::PW-1:0] point_y_i,
  input  logic signed [ppp_pkg::PW-1:0] point_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          visible_o,
  output logic signed [ppp_pkg::OW-1:0] screen_x_o,
  output logic signed [ppp_pkg::OW-1:0] screen_y_o,
  output logic [ppp_pkg::SW-1:0]        scale_o
);

  localparam int CW = ppp_pkg::CW;

  // configuration registers
  logic signed [ppp_pkg::PW-1:0] cam_x_q, cam_y_q, cam_z_q;
  logic [ppp_pkg::AW-1:0]        ang_x_q, ang_y_q, ang_z_q;
  logic [ppp_pkg::FW-1:0]        focal_q;
  logic                          trig_start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
      ang_x_q <= '0;
      ang_y_q <= '0;
      ang_z_q <= '0;
      focal_q <= ppp_pkg::FOCAL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ppp_pkg::CFG_CAMERA_X: cam_x_q <= cfg_data_i;
        ppp_pkg::CFG_CAMERA_Y: cam_y_q <= cfg_data_i;
        ppp_pkg::CFG_CAMERA_Z: cam_z_q <= cfg_data_i;
        ppp_pkg::CFG_ANGLE_X:  ang_x_q <= cfg_data_i[ppp_pkg::AW-1:0];
        ppp_pkg::CFG_ANGLE_Y:  ang_y_q <= cfg_data_i[ppp_pkg::AW-1:0];
        ppp_pkg::CFG_ANGLE_Z:  ang_z_q <= cfg_data_i[ppp_pkg::AW-1:0];
        ppp_pkg::CFG_FOCAL:    focal_q <= cfg_data_i[ppp_pkg::FW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // any angle change reloads the whole sine/cosine set
  assign trig_start = cfg_we_i && (cfg_idx_i == ppp_pkg::CFG_ANGLE_X ||
                                   cfg_idx_i == ppp_pkg::CFG_ANGLE_Y ||
                                   cfg_idx_i == ppp_pkg::CFG_ANGLE_Z);

  logic           trig_busy;
  ppp_pkg::trig_t trig;

  ppp_trig u_trig (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (trig_start),
    .angle_x_i (ang_x_q),
    .angle_y_i (ang_y_q),
    .angle_z_i (ang_z_q),
    .busy_o    (trig_busy),
    .trig_o    (trig)
  );

  // whole pipeline advances together unless the output skid is occupied
  logic pipe_en;

  assign in_ready_o = pipe_en && !trig_busy;

  // stage 0: camera-relative offset, exact in 25 bits
  logic signed [ppp_pkg::PW:0] dx, dy, dz;
  logic                        v0_q;
  logic signed [CW-1:0]        dx_q, dy_q, dz_q;

  assign dx = {point_x_i[ppp_pkg::PW-1], point_x_i} - {cam_x_q[ppp_pkg::PW-1], cam_x_q};
  assign dy = {point_y_i[ppp_pkg::PW-1], point_y_i} - {cam_y_q[ppp_pkg::PW-1], cam_y_q};
  assign dz = {point_z_i[ppp_pkg::PW-1], point_z_i} - {cam_z_q[ppp_pkg::PW-1], cam_z_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (pipe_en) begin
      v0_q <= in_valid_i && in_ready_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dx_q <= {{(CW-ppp_pkg::PW-1){dx[ppp_pkg::PW]}}, dx};
      dy_q <= {{(CW-ppp_pkg::PW-1){dy[ppp_pkg::PW]}}, dy};
      dz_q <= {{(CW-ppp_pkg::PW-1){dz[ppp_pkg::PW]}}, dz};
    end
  end

  // rotation about z: A, B; depth Z rides along
  logic                 vz;
  logic signed [CW-1:0] a_z, b_z, z_z;

  ppp_rot u_rot_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (v0_q),
    .p_i     (dy_q),
    .q_i     (dx_q),
    .r_i     (dz_q),
    .s_i     (trig.sz),
    .c_i     (trig.cz),
    .valid_o (vz),
    .u_o     (a_z),
    .v_o     (b_z),
    .r_o     (z_z)
  );

  // rotation about y: C, rx; B rides along
  logic                 vy;
  logic signed [CW-1:0] c_y, rx_y, b_y;

  ppp_rot u_rot_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (vz),
    .p_i     (a_z),
    .q_i     (z_z),
    .r_i     (b_z),
    .s_i     (trig.sy),
    .c_i     (trig.cy),
    .valid_o (vy),
    .u_o     (c_y),
    .v_o     (rx_y),
    .r_o     (b_y)
  );

  // rotation about x: ry, rz; rx rides along
  logic                 vx;
  logic signed [CW-1:0] ry_x, rz_x, rx_x;

  ppp_rot u_rot_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (vy),
    .p_i     (c_y),
    .q_i     (b_y),
    .r_i     (rx_y),
    .s_i     (trig.sx),
    .c_i     (trig.cx),
    .valid_o (vx),
    .u_o     (ry_x),
    .v_o     (rz_x),
    .r_o     (rx_x)
  );

  // near test and scale = focal / depth
  logic                   vd, vis_d;
  logic [ppp_pkg::SW-1:0] scale_d;
  logic signed [CW-1:0]   rx_d, ry_d;

  ppp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (vx),
    .rz_i    (rz_x),
    .rx_i    (rx_x),
    .ry_i    (ry_x),
    .focal_i (focal_q),
    .valid_o (vd),
    .vis_o   (vis_d),
    .scale_o (scale_d),
    .rx_o    (rx_d),
    .ry_o    (ry_d)
  );

  // screen mapping and output transaction register
  ppp_pkg::res_t res;

  ppp_out #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (vd),
    .vis_i       (vis_d),
    .scale_i     (scale_d),
    .rx_i        (rx_d),
    .ry_i        (ry_d),
    .out_ready_i (out_ready_i),
    .pipe_en_o   (pipe_en),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign visible_o  = res.vis;
  assign screen_x_o = res.sx;
  assign screen_y_o = res.sy;
  assign scale_o    = res.scale;

endmodule
